// ----- rtl/rau_pkg.sv -----
`default_nettype none
package rau_pkg;
   localparam int DefWidth = 32;

   typedef enum logic [2:0] {
      MODE_REDUCE = 3'd0,
      MODE_ADD    = 3'd1,
      MODE_SUB    = 3'd2,
      MODE_MUL    = 3'd3,
      MODE_DIV    = 3'd4,
      MODE_CMP    = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_ZDEN  = 2'd1,
      ST_OVFL  = 2'd2
   } status_type;

   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } div_ctl_type;
endpackage
`default_nettype wire

// ----- rtl/rational_arithmetic_unit_core.sv -----
// Rational arithmetic unit. Each request transaction carries a mode and two
// fractions; one response transaction returns the sum, difference, product,
// quotient or reduced first operand in lowest terms with a positive
// denominator, compare flags in compare mode, and a status (zero denominator
// or overflow). A zero denominator skips the gcd and goes from S_SUM through
// S_OUT to the response. Otherwise cross products on one shared multiplier,
// in states S_MUL1, S_MUL2 and S_SUM, come first. Then a shared 64-bit
// restoring divider runs one pass per Euclidean remainder step, followed by
// two exact divisions by the gcd. The block takes one transaction at a time;
// req_tready is high only while it is idle and the response register is
// empty.
`default_nettype none
module rational_arithmetic_unit_core #(
   parameter int WIDTH = rau_pkg::DefWidth
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // mode[2:0], a_num[34:3], a_den[66:35], b_num[98:67], b_den[130:99]
   input  wire logic [135:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // res_num[31:0], res_den[62:32], less[63], equal[64], greater[65], status[67:66]
   output logic [71:0]       rsp_tdata
);
   import rau_pkg::*;

   localparam int DW = 2 * WIDTH;

   typedef enum logic [7:0] {
      S_IDLE = 8'b00000001,
      S_MUL1 = 8'b00000010,
      S_MUL2 = 8'b00000100,
      S_SUM  = 8'b00001000,
      S_GCD  = 8'b00010000,
      S_DIVN = 8'b00100000,
      S_DIVD = 8'b01000000,
      S_OUT  = 8'b10000000
   } state_type;

   state_type state_ff, state_in;
   logic [2:0]        mode_ff, mode_in;
   logic [WIDTH-1:0]  an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in, bd_ff, bd_in;
   logic [DW-1:0]     p1_ff, p1_in, p2_ff, p2_in;
   logic              p1n_ff, p1n_in, p2n_ff, p2n_in;
   logic [DW:0]       nm_ff, nm_in;
   logic              nneg_ff, nneg_in;
   logic [DW-1:0]     dm_ff, dm_in;
   logic              dneg_ff, dneg_in;
   logic [DW-1:0]     gx_ff, gx_in, gy_ff, gy_in, nq_ff, nq_in;
   logic              lt_ff, lt_in, eq_ff, eq_in, gt_ff, gt_in;
   logic              go_ff, go_in;
   logic              ovn_ff, ovn_in;
   logic              zd_ff, zd_in;
   logic [71:0]       out_ff, out_in;
   logic              ov_ff, ov_in;

   logic              dstart;
   logic [DW-1:0]     dvd, dvs, quo, rem;
   div_ctl_type       dctl;

   logic [WIDTH-1:0]  ma, mb, m_mag_a, m_mag_b;
   logic              ma_neg, mb_neg;
   logic [DW-1:0]     mprod;
   logic [DW-1:0]     lim;
   logic              neg_res;
   logic [DW:0]       sum_a, sum_b;
   logic [DW:0]       sl, sr;

   rau_div #(.W(DW)) u_div (
      .clock(clock), .reset(reset), .start(dstart),
      .dividend(dvd), .divisor(dvs), .ctl(dctl), .quo(quo), .rem(rem)
   );

   function automatic logic [WIDTH-1:0] absw(input logic [WIDTH-1:0] v);
      absw = v[WIDTH-1] ? WIDTH'(-v) : v;
   endfunction

   // one shared multiplier over magnitudes
   always_comb begin
      ma = an_ff;
      mb = bd_ff;
      if (state_ff == S_MUL1 && mode_ff == MODE_MUL) begin
         ma = an_ff;
         mb = bn_ff;
      end else if (state_ff == S_MUL2) begin
         priority if (mode_ff == MODE_MUL) begin
            ma = ad_ff;
            mb = bd_ff;
         end else if (mode_ff == MODE_DIV) begin
            ma = ad_ff;
            mb = bn_ff;
         end else begin
            ma = bn_ff;
            mb = ad_ff;
         end
      end else if (state_ff == S_SUM) begin
         ma = ad_ff;
         mb = bd_ff;
      end
      ma_neg = ma[WIDTH-1];
      mb_neg = mb[WIDTH-1];
      m_mag_a = absw(ma);
      m_mag_b = absw(mb);
      mprod = DW'(m_mag_a) * DW'(m_mag_b);
   end

   assign lim = DW'(1) << (WIDTH - 1);
   assign sum_a = {1'b0, p1_ff};
   assign sum_b = {1'b0, p2_ff};
   assign sl = p1n_ff ? -sum_a : sum_a;
   assign sr = p2n_ff ? -sum_b : sum_b;

   always_comb begin
      state_in = state_ff;
      mode_in = mode_ff;
      an_in = an_ff; ad_in = ad_ff; bn_in = bn_ff; bd_in = bd_ff;
      p1_in = p1_ff; p1n_in = p1n_ff; p2_in = p2_ff; p2n_in = p2n_ff;
      nm_in = nm_ff; nneg_in = nneg_ff; dm_in = dm_ff; dneg_in = dneg_ff;
      gx_in = gx_ff; gy_in = gy_ff; nq_in = nq_ff;
      lt_in = lt_ff; eq_in = eq_ff; gt_in = gt_ff;
      go_in = 1'b0;
      ovn_in = ovn_ff;
      zd_in = zd_ff;
      out_in = out_ff;
      ov_in = ov_ff;
      dstart = 1'b0;
      dvd = gx_ff;
      dvs = gy_ff;
      neg_res = 1'b0;
      if (ov_ff && rsp_tready) ov_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && !ov_ff) begin
               mode_in = (req_tdata[2:0] > 3'd5) ? MODE_REDUCE : req_tdata[2:0];
               an_in = req_tdata[3 +: WIDTH];
               ad_in = req_tdata[35 +: WIDTH];
               bn_in = req_tdata[67 +: WIDTH];
               bd_in = req_tdata[99 +: WIDTH];
               lt_in = 1'b0; eq_in = 1'b0; gt_in = 1'b0;
               state_in = S_MUL1;
            end
         end
         S_MUL1: begin
            zd_in = (ad_ff == '0) || (mode_ff != MODE_REDUCE && bd_ff == '0) ||
                    (mode_ff == MODE_DIV && bn_ff == '0);
            p1_in = mprod;
            p1n_in = ma_neg ^ mb_neg;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            p2_in = mprod;
            p2n_in = (ma_neg ^ mb_neg) ^ (mode_ff == MODE_SUB);
            state_in = S_SUM;
         end
         S_SUM: begin
            unique case (mode_ff)
               MODE_ADD, MODE_SUB: begin
                  nm_in = ($signed(sl) + $signed(sr)) < 0 ?
                     -(sl + sr) : (sl + sr);
                  nneg_in = $signed(sl + sr) < 0;
                  dm_in = mprod;
                  dneg_in = ad_ff[WIDTH-1] ^ bd_ff[WIDTH-1];
               end
               MODE_MUL, MODE_DIV: begin
                  nm_in = {1'b0, p1_ff};
                  nneg_in = p1n_ff;
                  dm_in = p2_ff;
                  dneg_in = p2n_ff;
               end
               default: begin
                  nm_in = (DW + 1)'(absw(an_ff));
                  nneg_in = an_ff[WIDTH-1];
                  dm_in = DW'(absw(ad_ff));
                  dneg_in = ad_ff[WIDTH-1];
               end
            endcase
            if (mode_ff == MODE_CMP) begin
               // sl = an*bd, sr = bn*ad with signs
               eq_in = sl == sr;
               lt_in = (ad_ff[WIDTH-1] != bd_ff[WIDTH-1]) ?
                  ($signed(sl) > $signed(sr)) : ($signed(sl) < $signed(sr));
               gt_in = !(sl == sr) && !lt_in;
            end
            if (zd_ff) begin
               lt_in = 1'b0; eq_in = 1'b0; gt_in = 1'b0;
               state_in = S_OUT;
            end else begin
               gx_in = nm_in[DW-1:0];
               gy_in = dm_in;
               go_in = 1'b1;
               state_in = S_GCD;
            end
         end
         S_GCD: begin
            // x = y, y = x mod y until y is zero
            if (go_ff) begin
               if (gy_ff == '0) begin
                  dvd = nm_ff[DW-1:0];
                  dvs = gx_ff;
                  dstart = 1'b1;
                  state_in = S_DIVN;
               end else begin
                  dstart = 1'b1;
               end
            end else if (dctl.done) begin
               gx_in = gy_ff;
               gy_in = rem;
               go_in = 1'b1;
            end
         end
         S_DIVN: begin
            if (dctl.done) begin
               nq_in = quo;
               dvd = dm_ff;
               dvs = gx_ff;
               dstart = 1'b1;
               state_in = S_DIVD;
            end
         end
         S_DIVD: begin
            if (dctl.done) begin
               neg_res = (nneg_ff != dneg_ff) && nq_ff != '0;
               ovn_in = (quo > lim - 1'b1) ||
                        (neg_res ? nq_ff > lim : nq_ff > lim - 1'b1);
               out_in = '0;
               if (!ovn_in) begin
                  out_in[31:0] = 32'($signed(neg_res ? WIDTH'(-nq_ff) : nq_ff[WIDTH-1:0]));
                  out_in[62:32] = 31'(quo);
               end
               out_in[63] = lt_ff; out_in[64] = eq_ff; out_in[65] = gt_ff;
               out_in[67:66] = ovn_in ? ST_OVFL : ST_OK;
               ov_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_OUT: begin
            out_in = '0;
            out_in[67:66] = ST_ZDEN;
            ov_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      an_ff <= an_in; ad_ff <= ad_in; bn_ff <= bn_in; bd_ff <= bd_in;
      p1_ff <= p1_in; p1n_ff <= p1n_in; p2_ff <= p2_in; p2n_ff <= p2n_in;
      nm_ff <= nm_in; nneg_ff <= nneg_in; dm_ff <= dm_in; dneg_ff <= dneg_in;
      gx_ff <= gx_in; gy_ff <= gy_in; nq_ff <= nq_in;
      lt_ff <= lt_in; eq_ff <= eq_in; gt_ff <= gt_in;
      ovn_ff <= ovn_in; zd_ff <= zd_in;
      out_ff <= out_in;
      if (reset) begin
         state_ff <= S_IDLE;
         ov_ff <= 1'b0;
         go_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ov_ff <= ov_in;
         go_ff <= go_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE) && !ov_ff;
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata = out_ff;

   a_busy_no_ready: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req_tready) else $error("ready while busy");
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == S_MUL1) else $error("accept lost");
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> state_ff == S_IDLE) else $error("response while busy");
   a_flags_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot0(rsp_tdata[65:63])) else $error("flags clash");
endmodule
`default_nettype wire

// ----- rtl/rau_div.sv -----
`default_nettype none
module rau_div #(
   parameter int W = 64
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [W-1:0] dividend,
   input  wire logic [W-1:0] divisor,
   output rau_pkg::div_ctl_type ctl,
   output logic [W-1:0]      quo,
   output logic [W-1:0]      rem
);
   import rau_pkg::*;

   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  q_ff, q_in, r_ff, r_in, d_ff, d_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;
   logic [W:0]    trial;
   logic [W:0]    shl;

   // one quotient bit per cycle, restoring
   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shl = {r_ff, q_ff[W-1]};
      trial = shl - {1'b0, d_ff};
      if (start) begin
         q_in = dividend;
         r_in = '0;
         d_in = divisor;
         cnt_in = CW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[W]) begin
            r_in = trial[W-1:0];
            q_in = {q_ff[W-2:0], 1'b1};
         end else begin
            r_in = shl[W-1:0];
            q_in = {q_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
      if (reset) begin
         cnt_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign ctl.start = start;
   assign ctl.busy = busy_ff;
   assign ctl.done = done_ff;
   assign quo = q_ff;
   assign rem = r_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("done without busy");
   a_not_both: assert property (@(posedge clock) disable iff (reset)
      !(busy_ff && done_ff)) else $error("busy and done");
   a_cnt_zero_idle: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> cnt_ff == '0 || $past(start)) else $error("count left over");
endmodule
`default_nettype wire
